FILE: src/hsc_pkg.sv
// Shared constants, types and bit-mapping functions for the Hamming SEC codec.
package hsc_pkg;

  localparam int MAX_DATA_BITS = 26;
  localparam int DATA_W        = 26;
  localparam int CODE_W        = 31;
  localparam int SYN_W         = 5;
  localparam int STAT_W        = 2;
  localparam int NBITS_W       = 5;
  localparam int RBITS_W       = 3;
  localparam int CFG_DATA_W    = 5;

  localparam logic CFG_PARITY_ODD = 1'b0;
  localparam logic CFG_DATA_BITS  = 1'b1;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FIXED   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNCORR  = 2'd2;

  typedef struct packed {
    logic               odd;
    logic [RBITS_W-1:0] r;
    logic [NBITS_W-1:0] n;
  } code_cfg_t;

  function automatic logic is_pow2(input int pos);
    return (pos != 0) && ((pos & (pos - 1)) == 0);
  endfunction

  // data bit i goes to the i-th position that is not a power of two
  function automatic logic [CODE_W-1:0] scatter(input logic [DATA_W-1:0] data);
    logic [CODE_W-1:0] w;
    int idx;
    w   = '0;
    idx = 0;
    for (int pos = 1; pos <= CODE_W; pos++) begin
      if (!is_pow2(pos)) begin
        if (idx < DATA_W) begin
          w[pos-1] = data[idx];
        end
        idx++;
      end
    end
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] gather(input logic [CODE_W-1:0] w);
    logic [DATA_W-1:0] data;
    int idx;
    data = '0;
    idx  = 0;
    for (int pos = 1; pos <= CODE_W; pos++) begin
      if (!is_pow2(pos)) begin
        if (idx < DATA_W) begin
          data[idx] = w[pos-1];
        end
        idx++;
      end
    end
    return data;
  endfunction

  // positions covered by parity bit 2^g
  function automatic logic [CODE_W-1:0] group_mask(input int g);
    logic [CODE_W-1:0] m;
    for (int k = 0; k < CODE_W; k++) begin
      m[k] = (((k + 1) >> g) & 1) != 0;
    end
    return m;
  endfunction

endpackage

FILE: src/hsc_parity_tree.sv
// Parity group XOR trees: one syndrome or check bit per parity position.
module hsc_parity_tree
  import hsc_pkg::*;
(
  input  logic [CODE_W-1:0] word,
  input  code_cfg_t         cfg,
  output logic [SYN_W-1:0]  syn
);

  always_comb begin
    for (int g = 0; g < SYN_W; g++) begin
      if (RBITS_W'(g) < cfg.r) begin
        syn[g] = (^(word & group_mask(g))) ^ cfg.odd;
      end else begin
        syn[g] = 1'b0;
      end
    end
  end

endmodule

FILE: src/hamming_sec_codec.sv
// Top level of the Hamming single-error-correcting codec.
// Takes one request per cycle while the output side is ready and returns one result per
// request; the three register stages (mask and map, parity trees, insert check bits or
// correct, then extract data) pass each request on, and each stage holds under
// backpressure while free stages ahead of it keep filling. s_tdata: data_in[25:0],
// code_in[56:26]; s_tuser: kind. m_tdata: code_out[30:0], data_out[56:31],
// syndrome[61:57], status[63:62]. Configuration writes take effect for requests
// accepted after the write and must be made while the pipeline is empty.
module hamming_sec_codec
  import hsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // data_in, code_in
  input  logic                  s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [63:0]           m_tdata,   // code_out, data_out, syndrome, status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  parity_odd;
  logic [CFG_DATA_W-1:0] data_bits;

  logic [NBITS_W-1:0] d_eff;
  code_cfg_t          cfg;
  logic [31:0]        nmask_full;
  logic [31:0]        dmask_full;

  logic              v1, v2, v3;
  logic              kind1, kind2;
  logic [CODE_W-1:0] word1, word2;
  logic [SYN_W-1:0]  syn2;
  logic [SYN_W-1:0]  syn1_calc;
  logic              rdy1, rdy2, rdy3;

  logic [CODE_W-1:0] code3;
  logic [DATA_W-1:0] data3;
  logic [SYN_W-1:0]  syn3;
  logic [STAT_W-1:0] stat3;

  logic [CODE_W-1:0] code_next;
  logic [STAT_W-1:0] stat_next;
  logic [SYN_W-1:0]  syn_next;
  logic [CODE_W-1:0] word1_next;
  logic [DATA_W-1:0] din;
  logic [CODE_W-1:0] cin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_odd <= 1'b0;
      data_bits  <= CFG_DATA_W'(4);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PARITY_ODD: parity_odd <= cfg_data[0];
        CFG_DATA_BITS:  data_bits  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (data_bits == '0) begin
      d_eff = NBITS_W'(1);
    end else if (data_bits > CFG_DATA_W'(MAX_DATA_BITS)) begin
      d_eff = NBITS_W'(MAX_DATA_BITS);
    end else begin
      d_eff = data_bits;
    end
    case (d_eff) inside
      [5'd0:5'd1]:   cfg.r = RBITS_W'(2);
      [5'd2:5'd4]:   cfg.r = RBITS_W'(3);
      [5'd5:5'd11]:  cfg.r = RBITS_W'(4);
      default:       cfg.r = RBITS_W'(5);
    endcase
    cfg.n   = d_eff + NBITS_W'(cfg.r);
    cfg.odd = parity_odd;
  end

  assign nmask_full = (32'd1 << cfg.n) - 32'd1;
  assign dmask_full = (32'd1 << d_eff) - 32'd1;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // stage 1: mask unused bits, map data onto positions for encode requests
  assign din        = s_tdata[25:0] & dmask_full[DATA_W-1:0];
  assign cin        = s_tdata[56:26] & nmask_full[CODE_W-1:0];
  assign word1_next = (s_tuser == KIND_DECODE) ? cin : scatter(din);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      kind1 <= s_tuser;
      word1 <= word1_next;
    end
  end

  // stage 2: parity trees
  hsc_parity_tree u_tree (
    .word (word1),
    .cfg  (cfg),
    .syn  (syn1_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      kind2 <= kind1;
      word2 <= word1;
      syn2  <= syn1_calc;
    end
  end

  // stage 3: insert check bits or correct, then extract data
  always_comb begin
    code_next = word2;
    stat_next = STAT_OK;
    syn_next  = '0;
    if (kind2 == KIND_ENCODE) begin
      for (int g = 0; g < SYN_W; g++) begin
        code_next[(1 << g) - 1] = syn2[g];
      end
    end else begin
      syn_next = syn2;
      if (syn2 == '0) begin
        stat_next = STAT_OK;
      end else if (syn2 <= cfg.n) begin
        code_next = word2 ^ (CODE_W'(1) << (syn2 - SYN_W'(1)));
        stat_next = STAT_FIXED;
      end else begin
        stat_next = STAT_UNCORR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      code3 <= code_next;
      data3 <= gather(code_next);
      syn3  <= syn_next;
      stat3 <= stat_next;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {stat3, syn3, data3, code3};

endmodule
